### rtl/core/mpc_pkg.sv
// Shared types, codes and helpers for the moisture pump channel controller.
// Used by every module of the block but mpc_ram; depends on nothing else.
package mpc_pkg;

  localparam int NUM_CHANNELS_DEF        = 3;
  localparam int SAMPLES_PER_CHANNEL_DEF = 8;
  localparam int SUM_W                   = 15;

  localparam logic [14:0] SUM_MAX = 15'h7fff;

  localparam logic [2:0] REQ_GROUND  = 3'd0;
  localparam logic [2:0] REQ_POWERED = 3'd1;
  localparam logic [2:0] REQ_EVAL    = 3'd2;
  localparam logic [2:0] REQ_TICK    = 3'd3;
  localparam logic [2:0] REQ_SET     = 3'd4;

  localparam logic [1:0] ST_DISABLED = 2'd0;
  localparam logic [1:0] ST_NORMAL   = 2'd1;
  localparam logic [1:0] ST_WATERING = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [1:0] KIND_REPORT = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_ACK    = 2'd2;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_BAD  = 2'd1;
  localparam logic [1:0] ERR_BUSY = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  channel;
    logic [11:0] sample;
    logic [15:0] min_dryness;
    logic [15:0] max_dryness;
    logic [7:0]  max_cycles;
    logic [7:0]  cycle_time;
    logic [1:0]  new_status;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  channel_res;
    logic [15:0] reading;
    logic [1:0]  status;
    logic [7:0]  pumps;
    logic        watering_active;
    logic        round_done;
    logic [1:0]  error_code;
    logic        last;
  } out_item_t;

  // Per-channel entry of the state memory
  typedef struct packed {
    logic [15:0] low_thr;
    logic [15:0] high_thr;
    logic [7:0]  cycles_left;
    logic [7:0]  budget;
    logic [7:0]  on_time;
    logic [7:0]  counter;
    logic [1:0]  status;
    logic [15:0] reading;
  } state_entry_t;

  // Per-channel entry of the sample accumulator memory
  typedef struct packed {
    logic [SUM_W-1:0] ground;
    logic [SUM_W-1:0] powered;
  } sum_entry_t;

  function automatic state_entry_t reset_entry(input logic [2:0] ch);
    state_entry_t e;
    e.low_thr     = 16'd1100;
    e.high_thr    = 16'd1300;
    e.cycles_left = 8'd0;
    e.budget      = 8'd5;
    e.on_time     = 8'd7;
    e.counter     = 8'd0;
    e.status      = ST_DISABLED;
    e.reading     = 16'd0;
    case (ch)
      3'd0: begin
        e.low_thr  = 16'd550;
        e.high_thr = 16'd600;
        e.on_time  = 8'd5;
      end
      3'd1: e.on_time = 8'd10;
      default: ;
    endcase
    return e;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [11:0] v);
    logic [SUM_W:0] t;
    t = {1'b0, s} + {4'b0, v};
    return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
  endfunction

endpackage

### rtl/core/mpc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package needed.
module mpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/mpc_out_reg.sv
// Result output register: holds one result while the receiver stalls.
// Depends on mpc_pkg for the result type.
module mpc_out_reg import mpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      valid_r;
  out_item_t data_r;

  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
      data_r  <= push_data;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

endmodule

### rtl/core/mpc_ctrl.sv
// Request sequencer: read-modify-write of the per-channel state and sum memories.
// Depends on mpc_pkg and mpc_ram.
module mpc_ctrl import mpc_pkg::*; #(
  parameter int NUM_CHANNELS        = NUM_CHANNELS_DEF,
  parameter int SAMPLES_PER_CHANNEL = SAMPLES_PER_CHANNEL_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  input  logic      out_free,
  output logic      push,
  output out_item_t push_data
);

  localparam int AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ST_W   = $bits(state_entry_t);
  localparam int SUM_EW = $bits(sum_entry_t);
  localparam logic [AW-1:0] LAST_CH = AW'(NUM_CHANNELS - 1);
  localparam logic [3:0]    NCH     = 4'(NUM_CHANNELS);
  // Division by the sample count as a reciprocal multiply, exact for 15-bit sums
  localparam int DIV_SH = SUM_W + 3;
  localparam int DIV_MW = DIV_SH + 1;
  localparam logic [DIV_MW-1:0] DIV_M =
    DIV_MW'(((1 << DIV_SH) + SAMPLES_PER_CHANNEL - 1) / SAMPLES_PER_CHANNEL);

  typedef enum logic [3:0] {
    S_IDLE, S_SMP_RD, S_SMP_WR, S_EV_RD, S_EV_G, S_EV_P, S_EV_WR,
    S_REP_RD, S_REP_OUT, S_TK_RD, S_TK_WR, S_SET_RD, S_SET_CHK, S_EMIT
  } state_t;

  state_t                  state_r, state_nxt;
  in_item_t                req_r, req_nxt;
  out_item_t               res_r, res_nxt;
  logic [AW-1:0]           ch_r, ch_nxt;
  logic [NUM_CHANNELS-1:0] st_vld_r, st_vld_nxt;
  logic [NUM_CHANNELS-1:0] sum_vld_r, sum_vld_nxt;
  logic [NUM_CHANNELS-1:0] pump_r, pump_nxt;
  logic                    st_rvld_r, st_rvld_nxt;
  logic                    sum_rvld_r, sum_rvld_nxt;
  logic [AW-1:0]           st_raddr_r, st_raddr_nxt;
  logic [SUM_W-1:0]        g_avg_r, g_avg_nxt;
  logic [15:0]             rd_r, rd_nxt;
  logic                    any_r, any_nxt;
  logic                    busy_r, busy_nxt;
  logic                    inprog_r, inprog_nxt;

  logic                    st_re, st_we, sum_re, sum_we;
  logic [AW-1:0]           st_raddr, st_waddr, sum_raddr, sum_waddr;
  logic [ST_W-1:0]         st_rdata;
  logic [SUM_EW-1:0]       sum_rdata;
  state_entry_t            st_q, st_wdata;
  sum_entry_t              sum_q, sum_wdata;

  logic [SUM_W-1:0]        div_in;
  logic [SUM_W+DIV_MW-1:0] div_prod;
  logic [SUM_W-1:0]        div_q;

  logic [AW-1:0]           req_ch;
  logic                    req_ch_ok;

  mpc_ram #(.WIDTH(ST_W), .DEPTH(NUM_CHANNELS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mpc_ram #(.WIDTH(SUM_EW), .DEPTH(NUM_CHANNELS)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .re    (sum_re),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  // Entries never written read as their reset value
  assign st_q  = st_rvld_r ? state_entry_t'(st_rdata) : reset_entry(3'(st_raddr_r));
  assign sum_q = sum_rvld_r ? sum_entry_t'(sum_rdata) : '0;

  assign div_in   = (state_r == S_EV_G) ? sum_q.ground : sum_q.powered;
  assign div_prod = {{DIV_MW{1'b0}}, div_in} * {{SUM_W{1'b0}}, DIV_M};
  assign div_q    = div_prod[DIV_SH+SUM_W-1:DIV_SH];

  assign req_ch    = req_r.channel[AW-1:0];
  assign req_ch_ok = ({1'b0, in_data.channel} < NCH);
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_entry_t e;
    logic [1:0]   stt;
    logic [7:0]   cl;
    logic         water;
    logic         last_ch;

    state_nxt   = state_r;
    req_nxt     = req_r;
    res_nxt     = res_r;
    ch_nxt      = ch_r;
    st_vld_nxt  = st_vld_r;
    sum_vld_nxt = sum_vld_r;
    pump_nxt    = pump_r;
    g_avg_nxt   = g_avg_r;
    rd_nxt      = rd_r;
    any_nxt     = any_r;
    busy_nxt    = busy_r;
    inprog_nxt  = inprog_r;

    st_re     = 1'b0;
    st_we     = 1'b0;
    sum_re    = 1'b0;
    sum_we    = 1'b0;
    st_raddr  = ch_r;
    st_waddr  = ch_r;
    sum_raddr = ch_r;
    sum_waddr = ch_r;
    st_wdata  = st_q;
    sum_wdata = sum_q;

    e       = st_q;
    stt     = st_q.status;
    cl      = st_q.cycles_left;
    water   = 1'b0;
    last_ch = (ch_r == LAST_CH);

    push                      = 1'b0;
    push_data                 = res_r;
    push_data.pumps           = 8'(pump_r);
    push_data.watering_active = inprog_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data;
          ch_nxt   = '0;
          any_nxt  = 1'b0;
          busy_nxt = 1'b0;
          res_nxt  = '0;
          res_nxt.last = 1'b1;
          case (in_data.req_type)
            REQ_GROUND, REQ_POWERED: begin
              // drop samples for channels that do not exist
              if (req_ch_ok) state_nxt = S_SMP_RD;
            end
            REQ_EVAL: state_nxt = S_EV_RD;
            REQ_TICK: begin
              res_nxt.kind = KIND_TICK;
              state_nxt    = inprog_r ? S_TK_RD : S_EMIT;
            end
            REQ_SET: begin
              res_nxt.kind        = KIND_ACK;
              res_nxt.channel_res = in_data.channel;
              if (req_ch_ok) begin
                state_nxt = S_SET_RD;
              end else begin
                res_nxt.error_code = ERR_BAD;
                state_nxt          = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end

      S_SMP_RD: begin
        sum_re    = 1'b1;
        sum_raddr = req_ch;
        state_nxt = S_SMP_WR;
      end

      S_SMP_WR: begin
        sum_we    = 1'b1;
        sum_waddr = req_ch;
        if (req_r.req_type == REQ_GROUND) begin
          sum_wdata.ground = sat_add(sum_q.ground, req_r.sample);
        end else begin
          sum_wdata.powered = sat_add(sum_q.powered, req_r.sample);
        end
        sum_vld_nxt[req_ch] = 1'b1;
        state_nxt           = S_IDLE;
      end

      S_EV_RD: begin
        st_re     = 1'b1;
        sum_re    = 1'b1;
        state_nxt = S_EV_G;
      end

      S_EV_G: begin
        g_avg_nxt = div_q;
        state_nxt = S_EV_P;
      end

      S_EV_P: begin
        rd_nxt    = {1'b0, div_q} - {1'b0, g_avg_r};
        state_nxt = S_EV_WR;
      end

      S_EV_WR: begin
        if (stt == ST_DISABLED) begin
          pump_nxt[ch_r] = 1'b0;
        end else begin
          if (rd_r < st_q.low_thr && stt == ST_WATERING) stt = ST_NORMAL;
          if (rd_r > st_q.high_thr && cl == 8'd0 && stt == ST_NORMAL) begin
            cl  = st_q.budget;
            stt = ST_WATERING;
          end
          if (cl == 8'd0 && stt == ST_WATERING) stt = ST_OVERFLOW;
          if (stt == ST_WATERING) begin
            cl             = cl - 8'd1;
            e.counter      = st_q.on_time;
            pump_nxt[ch_r] = 1'b1;
            water          = 1'b1;
          end
        end
        e.status      = stt;
        e.cycles_left = cl;
        e.reading     = rd_r;
        st_we         = 1'b1;
        st_wdata      = e;
        st_vld_nxt[ch_r]  = 1'b1;
        sum_vld_nxt[ch_r] = 1'b0;
        any_nxt           = any_r | water;
        if (last_ch) begin
          if (any_r | water) inprog_nxt = 1'b1;
          ch_nxt    = '0;
          state_nxt = S_REP_RD;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_EV_RD;
        end
      end

      S_REP_RD: begin
        st_re     = 1'b1;
        state_nxt = S_REP_OUT;
      end

      S_REP_OUT: begin
        push_data.kind        = KIND_REPORT;
        push_data.channel_res = 3'(ch_r);
        push_data.reading     = st_q.reading;
        push_data.status      = st_q.status;
        push_data.round_done  = 1'b0;
        push_data.error_code  = ERR_OK;
        push_data.last        = last_ch;
        if (out_free) begin
          push = 1'b1;
          if (last_ch) begin
            state_nxt = S_IDLE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_REP_RD;
          end
        end
      end

      S_TK_RD: begin
        st_re     = 1'b1;
        state_nxt = S_TK_WR;
      end

      S_TK_WR: begin
        if (st_q.counter == 8'd0) begin
          pump_nxt[ch_r] = 1'b0;
        end else begin
          e.counter        = st_q.counter - 8'd1;
          st_we            = 1'b1;
          st_wdata         = e;
          st_vld_nxt[ch_r] = 1'b1;
          busy_nxt         = 1'b1;
        end
        if (last_ch) begin
          // round over once every counter has run out
          if (!busy_nxt) begin
            pump_nxt           = '0;
            inprog_nxt         = 1'b0;
            res_nxt.round_done = 1'b1;
          end
          state_nxt = S_EMIT;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_TK_RD;
        end
      end

      S_SET_RD: begin
        st_re     = 1'b1;
        st_raddr  = req_ch;
        state_nxt = S_SET_CHK;
      end

      S_SET_CHK: begin
        if (st_q.status == ST_WATERING || st_q.status == ST_OVERFLOW) begin
          res_nxt.status     = st_q.status;
          res_nxt.error_code = ERR_BUSY;
        end else begin
          e.low_thr     = req_r.min_dryness;
          e.high_thr    = req_r.max_dryness;
          e.cycles_left = 8'd0;
          e.budget      = req_r.max_cycles;
          e.on_time     = req_r.cycle_time;
          e.counter     = 8'd0;
          e.status      = req_r.new_status;
          st_we         = 1'b1;
          st_waddr      = req_ch;
          st_wdata      = e;
          st_vld_nxt[req_ch] = 1'b1;
          res_nxt.status     = req_r.new_status;
          res_nxt.error_code = ERR_OK;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    st_rvld_nxt  = st_re  ? st_vld_r[st_raddr]   : st_rvld_r;
    sum_rvld_nxt = sum_re ? sum_vld_r[sum_raddr] : sum_rvld_r;
    st_raddr_nxt = st_re  ? st_raddr             : st_raddr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ch_r       <= '0;
      st_vld_r   <= '0;
      sum_vld_r  <= '0;
      pump_r     <= '0;
      st_rvld_r  <= 1'b0;
      sum_rvld_r <= 1'b0;
      any_r      <= 1'b0;
      busy_r     <= 1'b0;
      inprog_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ch_r       <= ch_nxt;
      st_vld_r   <= st_vld_nxt;
      sum_vld_r  <= sum_vld_nxt;
      pump_r     <= pump_nxt;
      st_rvld_r  <= st_rvld_nxt;
      sum_rvld_r <= sum_rvld_nxt;
      any_r      <= any_nxt;
      busy_r     <= busy_nxt;
      inprog_r   <= inprog_nxt;
      req_r      <= req_nxt;
      res_r      <= res_nxt;
      st_raddr_r <= st_raddr_nxt;
      g_avg_r    <= g_avg_nxt;
      rd_r       <= rd_nxt;
    end
  end

endmodule

### rtl/core/moisture_pump_channel_controller.sv
// Flow, acceptance to result in the output register: a sample is added to its sum (no result);
// settings read, check and write the entry, then push an ack; a tick updates each channel's
// counter, or emits at once when idle; evaluate updates every channel, then reports each.
// One request at a time; the next is taken the cycle after the last push (after the write
// for a sample), as the single read port of the state memory and the shared reciprocal multiplier allow.
// Reset: rst_n synchronous, active low; per-channel defaults come from valid flags.
module moisture_pump_channel_controller import mpc_pkg::*; #(
  parameter int NUM_CHANNELS        = NUM_CHANNELS_DEF,
  parameter int SAMPLES_PER_CHANNEL = SAMPLES_PER_CHANNEL_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_free;
  logic      push;
  out_item_t push_data;

  mpc_ctrl #(
    .NUM_CHANNELS        (NUM_CHANNELS),
    .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_free  (out_free),
    .push      (push),
    .push_data (push_data)
  );

  mpc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/core/mpc_checker.sv
// Port-level checks of the moisture pump channel controller, bound to the top.
// Depends on mpc_pkg.
module mpc_checker import mpc_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // hold a stalled request
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_round_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.round_done |->
      out_data.pumps == 8'd0 && !out_data.watering_active)
    else $error("round done with pumps still on");

  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_TICK |->
      out_data.last && out_data.channel_res == 3'd0 && out_data.reading == 16'd0 &&
      out_data.error_code == ERR_OK)
    else $error("malformed tick status");

  a_pumps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pumps >> NUM_CHANNELS) == 8'd0)
    else $error("pump driven for absent channel");

endmodule

bind moisture_pump_channel_controller mpc_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_mpc_checker (.*);
